/* hw/rtl/sfml_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfml_pkg
// Shared types and constants for the subsampled frame mean luma block.
// ----------------------------------------------------------------------------
package sfml_pkg;

  localparam int CFG_W      = 13;
  localparam int DIM_W      = 12;
  localparam int MAX_DIM    = 4096;
  localparam int SAMPLE_LG  = 3;    // sample step of 8 pixels in both axes
  localparam int PIX_W      = 8;
  localparam int TOTAL_W    = 27;
  localparam int COUNT_W    = 19;
  localparam int MEAN_W     = 16;
  localparam int NUM_W      = TOTAL_W + MEAN_W;
  localparam int STEP_W     = 4;    // counts the quotient bits

  localparam logic [PIX_W-1:0] LUMA_RED_WEIGHT   = 8'd54;
  localparam logic [PIX_W-1:0] LUMA_GREEN_WEIGHT = 8'd183;
  localparam logic [PIX_W-1:0] LUMA_BLUE_WEIGHT  = 8'd19;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-frame sums handed from the accumulator to the divider
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } frame_sum_t;

  // Last valid position for a dimension register: zero acts as one,
  // anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m1;
    m1 = v - CFG_W'(1);
    if (v == '0) begin
      dim_last = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      dim_last = DIM_W'(MAX_DIM - 1);
    end else begin
      dim_last = m1[DIM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/subsampled_frame_mean_luma.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subsampled_frame_mean_luma
// Mean luma of each frame, sampled on an 8x8 pixel grid.
//
// Pixels enter in raster order on the in_ stream, one BGR pixel per beat.
// Frame size comes from two registers written on the cfg_ port (index 0 is
// frame width, index 1 is frame height, both 640 after reset). On the last
// pixel of a frame the block emits one out_ beat carrying the mean luma as
// a 16-bit fraction, 65535 meaning full scale.
// Throughput: one pixel per cycle while the queue has room. The per-frame
// sums pass through a two-entry queue to a single restoring divider that
// loads, computes 16 quotient bits and outputs one frame at a time, so
// short frames throttle in_tready once the queue fills.
// A frame's result passes the stage register, the queue, the divider's
// load, quotient and done states, then the output register.
// Reset clears the counters, sums, queue and output valid flag; rst_n is
// synchronous. When the receiver stalls, the result waits in the output
// register while the next frame keeps streaming and its sums queue up.
// ----------------------------------------------------------------------------
module subsampled_frame_mean_luma
  import sfml_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [23:0]        in_tdata,   // blue [7:0], green [15:8], red [23:16]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [MEAN_W-1:0]       out_tdata   // mean_luma [15:0]
);

  logic [QCNT_W-1:0] q_free;
  logic              sum_push, q_valid, q_pop;
  frame_sum_t        sum_data, q_data;

  sfml_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_blue   (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_red    (in_tdata[23:16]),
    .q_free    (q_free),
    .sum_push  (sum_push),
    .sum_data  (sum_data)
  );

  sfml_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (sum_push),
    .push_data (sum_data),
    .free      (q_free),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  sfml_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* hw/rtl/sfml_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfml_front
// Pixel intake: position counters, luma, subsample select and per-frame sums.
// ----------------------------------------------------------------------------
module sfml_front
  import sfml_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire cfg_reg_t           cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [PIX_W-1:0]   in_blue,
  input  wire logic [PIX_W-1:0]   in_green,
  input  wire logic [PIX_W-1:0]   in_red,
  input  wire logic [QCNT_W-1:0]  q_free,
  output logic                    sum_push,
  output frame_sum_t              sum_data
);

  logic [CFG_W-1:0]   width_r, height_r;
  logic [DIM_W-1:0]   col_r, row_r;
  logic [PIX_W-1:0]   luma_r;
  logic               smp_r, eof_r, vld_r;
  logic [TOTAL_W-1:0] total_r;
  logic [COUNT_W-1:0] count_r;

  logic               in_accept;
  logic [15:0]        luma_full;
  logic               sample, last_col, last_row, eof;
  logic [TOTAL_W-1:0] tot_sum;
  logic [COUNT_W-1:0] cnt_sum;

  assign cfg_ready = 1'b1;

  // one frame may still sit in the stage register on its way to the queue
  assign in_tready = q_free > QCNT_W'(vld_r && eof_r);
  assign in_accept = in_tvalid && in_tready;

  assign luma_full = {8'd0, in_red}   * {8'd0, LUMA_RED_WEIGHT}
                   + {8'd0, in_green} * {8'd0, LUMA_GREEN_WEIGHT}
                   + {8'd0, in_blue}  * {8'd0, LUMA_BLUE_WEIGHT};

  assign sample   = (col_r[SAMPLE_LG-1:0] == '0) && (row_r[SAMPLE_LG-1:0] == '0);
  assign last_col = col_r >= dim_last(width_r);
  assign last_row = row_r >= dim_last(height_r);
  assign eof      = last_col && last_row;

  assign tot_sum  = total_r + (smp_r ? TOTAL_W'(luma_r) : '0);
  assign cnt_sum  = count_r + COUNT_W'(smp_r);

  assign sum_push       = vld_r && eof_r;
  assign sum_data.total = tot_sum;
  assign sum_data.count = cnt_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(640);
      col_r    <= '0;
      row_r    <= '0;
      vld_r    <= 1'b0;
      total_r  <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: height_r <= cfg_data;
          default:          width_r  <= width_r;
        endcase
      end
      if (in_accept) begin
        if (!last_col) begin
          col_r <= col_r + DIM_W'(1);
        end else if (!last_row) begin
          col_r <= '0;
          row_r <= row_r + DIM_W'(1);
        end else begin
          col_r <= '0;
          row_r <= '0;
        end
      end
      vld_r <= in_accept;
      // accumulate the staged beat; clear after handing off a frame
      if (vld_r) begin
        if (eof_r) begin
          total_r <= '0;
          count_r <= '0;
        end else begin
          total_r <= tot_sum;
          count_r <= cnt_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      luma_r <= luma_full[15:8];
      smp_r  <= sample;
      eof_r  <= eof;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    sum_push |-> q_free != '0)
    else $error("frame sums pushed into a full queue");

  a_eof_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && eof) |=> sum_push)
    else $error("end of frame did not reach the queue");

endmodule
`default_nettype wire

/* hw/rtl/sfml_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfml_queue
// Short queue of per-frame sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module sfml_queue
  import sfml_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire frame_sum_t         push_data,
  output logic [QCNT_W-1:0]       free,
  output logic                    pop_valid,
  input  wire logic               pop,
  output frame_sum_t              pop_data
);

  frame_sum_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign do_push   = push && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop    = pop && (cnt_r != '0);
  assign free      = QCNT_W'(QUEUE_DEPTH) - cnt_r;
  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule
`default_nettype wire

/* hw/rtl/sfml_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfml_back
// Mean computation: total*65535 / (255*count), one quotient bit per cycle,
// into an output register.
// ----------------------------------------------------------------------------
module sfml_back
  import sfml_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire frame_sum_t         q_data,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [MEAN_W-1:0]       out_tdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [TOTAL_W-1:0]  rem_r, rem_nxt;
  logic [MEAN_W-1:0]   quo_r, quo_nxt;
  logic [TOTAL_W-1:0]  den_r, den_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;

  logic [NUM_W-1:0]    num;
  logic [TOTAL_W:0]    shifted, diff;
  logic                ge;

  // total*65535 and count*255 as shift-and-subtract
  assign num     = {q_data.total, {MEAN_W{1'b0}}} - NUM_W'(q_data.total);
  assign shifted = {rem_r, quo_r[MEAN_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = mean_r;

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    den_nxt     = den_r;
    step_nxt    = step_r;
    mean_nxt    = mean_r;
    out_vld_nxt = out_vld_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          rem_nxt   = num[NUM_W-1:MEAN_W];
          quo_nxt   = num[MEAN_W-1:0];
          den_nxt   = {q_data.count, 8'd0} - TOTAL_W'(q_data.count);
          step_nxt  = STEP_W'(MEAN_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
        quo_nxt  = {quo_r[MEAN_W-2:0], ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the quotient until the output register frees up
        if (!out_vld_r || out_tready) begin
          mean_nxt    = (den_r == '0) ? '0 : quo_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    step_r <= step_nxt;
    mean_r <= mean_nxt;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && den_r != '0) |-> rem_r < den_r)
    else $error("partial remainder reached the divisor");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(state_r) == ST_DONE)
    else $error("output loaded outside the done state");

endmodule
`default_nettype wire
